// ----- rtl/core/udrb_pkg.sv -----
// Shared types and op codes for the dual UART ring buffer.
package udrb_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LevelW = 7;

  typedef enum logic [1:0] {
    OP_LINE_RX  = 2'd0,
    OP_TX_READY = 2'd1,
    OP_SW_PUSH  = 2'd2,
    OP_SW_READ  = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] data_byte;
    logic             last_of_block;
  } in_item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [ByteW-1:0]  tx_byte;
    logic              read_valid;
    logic [ByteW-1:0]  read_byte;
    logic [LevelW-1:0] rx_level;
    logic [LevelW-1:0] tx_level;
    logic              tx_active;
    logic              rx_overwrote;
    logic              push_dropped;
  } out_item_t;

  // Result fields known at issue; the bytes arrive later from the registered read ports of the rings.
  typedef struct packed {
    logic              tx_valid;
    logic              read_valid;
    logic [LevelW-1:0] rx_level;
    logic [LevelW-1:0] tx_level;
    logic              tx_active;
    logic              rx_overwrote;
    logic              push_dropped;
  } issue_t;

endpackage

// ----- rtl/core/udrb_in_if.sv -----
// Valid/ready channel that carries input items.
interface udrb_in_if
  import udrb_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/udrb_out_if.sv -----
// Valid/ready channel that carries result items.
interface udrb_out_if
  import udrb_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/uart_dual_ring_buffer_top.sv -----
// Dual UART byte rings: receive ring overwrites oldest, transmit ring drops when full.
// A result goes through the issue and output registers after its item is accepted.
// Throughput: one item per cycle while the result side is not stalled;
// pointers update at acceptance and the ring byte comes from each RAM's
// registered read port. Reset clears heads, counts, the drain flag and the
// pipeline valids; ring contents are not cleared and need no clearing pass.
module uart_dual_ring_buffer_top
  import udrb_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  udrb_in_if.sink    item_i,
  udrb_out_if.source result_o
);

  localparam int unsigned RxAw = $clog2(RX_DEPTH);
  localparam int unsigned TxAw = $clog2(TX_DEPTH);
  localparam int unsigned RxCw = $clog2(RX_DEPTH + 1);
  localparam int unsigned TxCw = $clog2(TX_DEPTH + 1);
  localparam logic [RxCw-1:0] RxFull = RxCw'(RX_DEPTH);
  localparam logic [TxCw-1:0] TxFull = TxCw'(TX_DEPTH);
  localparam logic [RxAw-1:0] RxLast = RxAw'(RX_DEPTH - 1);
  localparam logic [TxAw-1:0] TxLast = TxAw'(TX_DEPTH - 1);
  localparam logic [RxAw:0]   RxDep1 = (RxAw + 1)'(RX_DEPTH);
  localparam logic [TxAw:0]   TxDep1 = (TxAw + 1)'(TX_DEPTH);

  logic [RxAw-1:0] rx_head_q, rx_head_d;
  logic [RxCw-1:0] rx_cnt_q, rx_cnt_d;
  logic [TxAw-1:0] tx_head_q, tx_head_d;
  logic [TxCw-1:0] tx_cnt_q, tx_cnt_d;
  logic            drain_q, drain_d;
  logic            s1_valid_q, s1_valid_d;
  issue_t          s1_q, s1_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            in_fire, out_free;
  logic [RxAw:0]   rx_sum;
  logic [TxAw:0]   tx_sum;
  logic [RxAw-1:0] rx_tail, rx_head_inc;
  logic [TxAw-1:0] tx_tail, tx_head_inc;
  logic            rx_we, rx_re, tx_we, tx_re;
  logic [ByteW-1:0] rx_rdata, tx_rdata;

  assign out_free     = !out_valid_q || result_o.ready;
  assign item_i.ready = !s1_valid_q || out_free;
  assign in_fire      = item_i.valid && item_i.ready;

  // Tail slot is head plus count, wrapped once.
  assign rx_sum      = {1'b0, rx_head_q} + (RxAw + 1)'(rx_cnt_q);
  assign rx_tail     = (rx_sum >= RxDep1) ? RxAw'(rx_sum - RxDep1) : RxAw'(rx_sum);
  assign tx_sum      = {1'b0, tx_head_q} + (TxAw + 1)'(tx_cnt_q);
  assign tx_tail     = (tx_sum >= TxDep1) ? TxAw'(tx_sum - TxDep1) : TxAw'(tx_sum);
  assign rx_head_inc = (rx_head_q == RxLast) ? '0 : rx_head_q + 1'b1;
  assign tx_head_inc = (tx_head_q == TxLast) ? '0 : tx_head_q + 1'b1;

  always_comb begin
    rx_head_d = rx_head_q;
    rx_cnt_d  = rx_cnt_q;
    tx_head_d = tx_head_q;
    tx_cnt_d  = tx_cnt_q;
    drain_d   = drain_q;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    s1_d      = '0;

    if (in_fire) begin
      unique case (item_i.data.op)
        OP_LINE_RX: begin
          rx_we = 1'b1;
          if (rx_cnt_q == RxFull) begin
            rx_head_d         = rx_head_inc;
            s1_d.rx_overwrote = 1'b1;
          end else begin
            rx_cnt_d = rx_cnt_q + 1'b1;
          end
        end
        OP_TX_READY: begin
          if (tx_cnt_q != '0) begin
            tx_re         = 1'b1;
            s1_d.tx_valid = 1'b1;
            tx_cnt_d      = tx_cnt_q - 1'b1;
            tx_head_d     = tx_head_inc;
          end else begin
            drain_d = 1'b0;
          end
        end
        OP_SW_PUSH: begin
          if (tx_cnt_q == TxFull) begin
            s1_d.push_dropped = 1'b1;
          end else begin
            tx_we    = 1'b1;
            tx_cnt_d = tx_cnt_q + 1'b1;
            drain_d  = 1'b1;
          end
        end
        OP_SW_READ: begin
          if (rx_cnt_q != '0) begin
            rx_re           = 1'b1;
            s1_d.read_valid = 1'b1;
            rx_cnt_d        = rx_cnt_q - 1'b1;
            rx_head_d       = rx_head_inc;
          end
        end
        default: ;
      endcase
    end

    s1_d.rx_level  = LevelW'(rx_cnt_d);
    s1_d.tx_level  = LevelW'(tx_cnt_d);
    s1_d.tx_active = drain_d;
  end

  // Advance the issue stage into the output register when the output frees up.
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (item_i.ready) begin
      s1_valid_d = in_fire;
    end
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end

    out_d.tx_valid     = s1_q.tx_valid;
    out_d.tx_byte      = s1_q.tx_valid ? tx_rdata : '0;
    out_d.read_valid   = s1_q.read_valid;
    out_d.read_byte    = s1_q.read_valid ? rx_rdata : '0;
    out_d.rx_level     = s1_q.rx_level;
    out_d.tx_level     = s1_q.tx_level;
    out_d.tx_active    = s1_q.tx_active;
    out_d.rx_overwrote = s1_q.rx_overwrote;
    out_d.push_dropped = s1_q.push_dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q   <= '0;
      rx_cnt_q    <= '0;
      tx_head_q   <= '0;
      tx_cnt_q    <= '0;
      drain_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rx_head_q   <= rx_head_d;
      rx_cnt_q    <= rx_cnt_d;
      tx_head_q   <= tx_head_d;
      tx_cnt_q    <= tx_cnt_d;
      drain_q     <= drain_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (out_free && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  udrb_ram #(
    .WIDTH (ByteW),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_tail),
    .wdata_i (item_i.data.data_byte),
    .re_i    (rx_re),
    .raddr_i (rx_head_q),
    .rdata_o (rx_rdata)
  );

  udrb_ram #(
    .WIDTH (ByteW),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_tail),
    .wdata_i (item_i.data.data_byte),
    .re_i    (tx_re),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

// ----- rtl/core/udrb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module udrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- dv/tb_uart_dual_ring_buffer_top.sv -----
// Self-checking testbench for the dual UART ring buffer top level.
module tb_uart_dual_ring_buffer_top;
  import udrb_pkg::*;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk_i;
  logic rst_ni;

  udrb_in_if  in_ch ();
  udrb_out_if out_ch ();

  uart_dual_ring_buffer_top #(
    .RX_DEPTH(RING_DEPTH),
    .TX_DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_ch),
    .result_o(out_ch)
  );

  // Local copy of both rings
  logic [ByteW-1:0]  rx_bytes [RING_DEPTH];
  logic [ByteW-1:0]  tx_bytes [RING_DEPTH];
  logic [PTR_W-1:0]  rx_rd_ptr;
  logic [LevelW-1:0] rx_fill;
  logic [PTR_W-1:0]  tx_rd_ptr;
  logic [LevelW-1:0] tx_fill;
  logic              drain_en;

  out_item_t   ring_results_due [$];
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  bit          gap_en;
  bit          stall_en;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic in_item_t mk_event(op_e op, logic [ByteW-1:0] b, logic last);
    in_item_t it;
    it.op            = op;
    it.data_byte     = b;
    it.last_of_block = last;
    return it;
  endfunction

  function automatic out_item_t predict_ring_step(in_item_t it);
    out_item_t        res;
    logic [PTR_W-1:0] slot;
    res = '0;
    case (it.op)
      OP_LINE_RX: begin
        // A full ring overwrites the oldest byte and moves the head on
        slot = rx_rd_ptr + rx_fill[PTR_W-1:0];
        rx_bytes[slot] = it.data_byte;
        if (rx_fill >= RING_DEPTH) begin
          rx_rd_ptr = rx_rd_ptr + 1'b1;
          res.rx_overwrote = 1'b1;
        end else begin
          rx_fill = rx_fill + 1'b1;
        end
      end
      OP_TX_READY: begin
        if (tx_fill != 0) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = tx_bytes[tx_rd_ptr];
          tx_fill      = tx_fill - 1'b1;
          tx_rd_ptr    = tx_rd_ptr + 1'b1;
        end else begin
          drain_en = 1'b0;
        end
      end
      OP_SW_PUSH: begin
        if (tx_fill >= RING_DEPTH) begin
          res.push_dropped = 1'b1;
        end else begin
          slot = tx_rd_ptr + tx_fill[PTR_W-1:0];
          tx_bytes[slot] = it.data_byte;
          tx_fill  = tx_fill + 1'b1;
          drain_en = 1'b1;
        end
      end
      default: begin
        if (rx_fill != 0) begin
          res.read_valid = 1'b1;
          res.read_byte  = rx_bytes[rx_rd_ptr];
          rx_fill        = rx_fill - 1'b1;
          rx_rd_ptr      = rx_rd_ptr + 1'b1;
        end
      end
    endcase
    res.rx_level  = rx_fill;
    res.tx_level  = tx_fill;
    res.tx_active = drain_en;
    return res;
  endfunction

  function automatic void check_field(string fname, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      error_cnt++;
    end
  endfunction

  // Predict on input acceptance, then check any result taken at the same edge
  always @(posedge clk_i) begin
    out_item_t exp_r;
    out_item_t act_r;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        ring_results_due.push_back(predict_ring_step(in_ch.data));
      end
      if (out_ch.valid && out_ch.ready) begin
        act_r = out_ch.data;
        if (ring_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, act_r);
          error_cnt++;
        end else begin
          exp_r = ring_results_due.pop_front();
          check_field("tx_valid", 8'(exp_r.tx_valid), 8'(act_r.tx_valid));
          check_field("tx_byte", exp_r.tx_byte, act_r.tx_byte);
          check_field("read_valid", 8'(exp_r.read_valid), 8'(act_r.read_valid));
          check_field("read_byte", exp_r.read_byte, act_r.read_byte);
          check_field("rx_level", 8'(exp_r.rx_level), 8'(act_r.rx_level));
          check_field("tx_level", 8'(exp_r.tx_level), 8'(act_r.tx_level));
          check_field("tx_active", 8'(exp_r.tx_active), 8'(act_r.tx_active));
          check_field("rx_overwrote", 8'(exp_r.rx_overwrote), 8'(act_r.rx_overwrote));
          check_field("push_dropped", 8'(exp_r.push_dropped), 8'(act_r.push_dropped));
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_ch.ready <= stall_en ? ($urandom_range(99) >= 25) : 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_event(input in_item_t it);
    if (gap_en && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic test_directed();
    gap_en   = 1'b1;
    stall_en = 1'b1;
    send_event(mk_event(OP_SW_READ, 8'h00, 1'b0));   // read from empty ring
    send_event(mk_event(OP_TX_READY, 8'h00, 1'b0));  // ready with drain already off
    send_event(mk_event(OP_SW_PUSH, 8'h00, 1'b0));
    send_event(mk_event(OP_SW_PUSH, 8'hFF, 1'b1));
    send_event(mk_event(OP_LINE_RX, 8'h00, 1'b0));
    send_event(mk_event(OP_LINE_RX, 8'hFF, 1'b1));
    send_event(mk_event(OP_TX_READY, 8'hFF, 1'b1));
    send_event(mk_event(OP_SW_READ, 8'hFF, 1'b1));
    send_event(mk_event(OP_TX_READY, 8'h00, 1'b0));
    send_event(mk_event(OP_TX_READY, 8'h00, 1'b0));  // empty ring clears the drain
    send_event(mk_event(OP_SW_READ, 8'h00, 1'b0));
    send_event(mk_event(OP_SW_READ, 8'h00, 1'b0));
    send_event(mk_event(OP_SW_PUSH, 8'hAA, 1'b0));
    send_event(mk_event(OP_SW_PUSH, 8'h55, 1'b1));
    send_event(mk_event(OP_LINE_RX, 8'h5A, 1'b0));
    send_event(mk_event(OP_LINE_RX, 8'hA5, 1'b1));
    send_event(mk_event(OP_TX_READY, 8'h00, 1'b0));
    send_event(mk_event(OP_SW_READ, 8'h00, 1'b0));
    send_event(mk_event(OP_TX_READY, 8'h00, 1'b0));
    send_event(mk_event(OP_TX_READY, 8'h00, 1'b0));
    send_event(mk_event(OP_SW_READ, 8'h00, 1'b0));
    send_event(mk_event(OP_SW_READ, 8'h00, 1'b0));
  endtask

  // Phases lean toward filling, toward draining or to neither, so both rings hit full and empty
  task automatic test_random_traffic(input int unsigned n_items, input bit with_idle);
    int unsigned sent;
    int unsigned phase_len;
    int unsigned lean;
    int unsigned roll;
    op_e         op;
    gap_en   = with_idle;
    stall_en = with_idle;
    sent     = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(40, 140);
      if (phase_len > n_items - sent) begin
        phase_len = n_items - sent;
      end
      lean      = $urandom_range(2);
      repeat (phase_len) begin
        roll = $urandom_range(99);
        case (lean)
          0: op = (roll < 80) ? (roll[0] ? OP_LINE_RX : OP_SW_PUSH)
                              : (roll[0] ? OP_TX_READY : OP_SW_READ);
          1: op = (roll < 80) ? (roll[0] ? OP_TX_READY : OP_SW_READ)
                              : (roll[0] ? OP_LINE_RX : OP_SW_PUSH);
          default: op = op_e'($urandom_range(3));
        endcase
        send_event(mk_event(op, 8'($urandom_range(255)), 1'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    error_cnt    = 0;
    cycle_cnt    = 0;
    gap_en       = 1'b0;
    stall_en     = 1'b0;
    rx_rd_ptr    = '0;
    rx_fill      = '0;
    tx_rd_ptr    = '0;
    tx_fill      = '0;
    drain_en     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(550, 1'b1);
    test_random_traffic(330, 1'b0);
    test_random_traffic(100, 1'b1);

    in_ch.valid <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/udrb_pkg.sv
rtl/core/udrb_in_if.sv
rtl/core/udrb_out_if.sv
rtl/core/udrb_ram.sv
rtl/core/uart_dual_ring_buffer_top.sv
dv/tb_uart_dual_ring_buffer_top.sv
